// ===== rtl/etipf_pkg.sv =====
package etipf_pkg;

  // table geometry: the tables are spread over a row of cells
  localparam int TABLE_DEPTH  = 64;
  localparam int CELL_ENTRIES = 4;
  localparam int NUM_CELLS    = TABLE_DEPTH / CELL_ENTRIES;
  localparam int INDEX_W      = $clog2(TABLE_DEPTH);
  localparam int SLOT_W       = $clog2(CELL_ENTRIES);
  localparam int CELL_ID_W    = INDEX_W - SLOT_W;

  // field widths
  localparam int KIND_W       = 2;
  localparam int ENTRY_IDX_W  = 6;
  localparam int TYPE_W       = 16;
  localparam int PROTO_W      = 8;
  localparam int LEN_W        = 16;
  localparam int COUNT_W      = 7;
  localparam int TOTAL_W      = 32;
  localparam int BYTE_TOTAL_W = 48;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 7;

  localparam logic [TYPE_W-1:0] TYPE_VLAN = 16'h8100;
  localparam logic [TYPE_W-1:0] TYPE_IPV4 = 16'h0800;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ETHERTYPE_LOAD = 2'd0,
    KIND_PROTOCOL_LOAD  = 2'd1,
    KIND_CLASSIFY       = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ETHERTYPE_COUNT = 2'd0,
    CFG_PROTOCOL_COUNT  = 2'd1,
    CFG_MATCH_ACTION    = 2'd2,
    CFG_DEFAULT_ACTION  = 2'd3
  } cfg_reg_t;

  // search limits shared by all cells
  typedef struct packed {
    logic [COUNT_W-1:0] ethertype_count;
    logic [COUNT_W-1:0] protocol_count;
  } cell_cfg_t;

  // token handed from cell to cell
  typedef struct packed {
    logic               valid;
    kind_t              op;
    logic [INDEX_W-1:0] index;
    logic [TYPE_W-1:0]  value;
    logic [TYPE_W-1:0]  outer_type;
    logic [PROTO_W-1:0] proto;
    logic               is_ipv4;
    logic               eth_hit;
    logic               proto_hit;
    logic [LEN_W-1:0]   length;
  } token_t;

endpackage

// ===== rtl/etipf_pkt_if.sv =====
interface etipf_pkt_if;
  logic                              valid;
  logic                              ready;
  logic [etipf_pkg::KIND_W-1:0]      kind;
  logic [etipf_pkg::ENTRY_IDX_W-1:0] entry_index;
  logic [etipf_pkg::TYPE_W-1:0]      entry_value;
  logic [etipf_pkg::TYPE_W-1:0]      outer_type;
  logic [etipf_pkg::TYPE_W-1:0]      tag_inner_type;
  logic [etipf_pkg::PROTO_W-1:0]     proto_untagged;
  logic [etipf_pkg::PROTO_W-1:0]     proto_tagged;
  logic [etipf_pkg::LEN_W-1:0]       packet_length;

  modport source (
    output valid, kind, entry_index, entry_value, outer_type, tag_inner_type,
           proto_untagged, proto_tagged, packet_length,
    input  ready
  );

  modport sink (
    input  valid, kind, entry_index, entry_value, outer_type, tag_inner_type,
           proto_untagged, proto_tagged, packet_length,
    output ready
  );
endinterface

// ===== rtl/etipf_res_if.sv =====
interface etipf_res_if;
  logic                               valid;
  logic                               ready;
  logic                               verdict_pass;
  logic                               matched;
  logic [etipf_pkg::TOTAL_W-1:0]      match_total;
  logic [etipf_pkg::TOTAL_W-1:0]      drop_total;
  logic [etipf_pkg::TOTAL_W-1:0]      pass_total;
  logic [etipf_pkg::BYTE_TOTAL_W-1:0] pass_byte_total;

  modport source (
    output valid, verdict_pass, matched, match_total, drop_total, pass_total,
           pass_byte_total,
    input  ready
  );

  modport sink (
    input  valid, verdict_pass, matched, match_total, drop_total, pass_total,
           pass_byte_total,
    output ready
  );
endinterface

// ===== rtl/etipf_cell.sv =====
module etipf_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic [etipf_pkg::CELL_ID_W-1:0] cell_id,
  input  etipf_pkg::cell_cfg_t           cfg,
  input  etipf_pkg::token_t              tok_in,
  output etipf_pkg::token_t              tok_out
);

  logic [etipf_pkg::TYPE_W-1:0]  eth_entry   [etipf_pkg::CELL_ENTRIES];
  logic [etipf_pkg::PROTO_W-1:0] proto_entry [etipf_pkg::CELL_ENTRIES];

  logic                          eth_hit_here;
  logic                          proto_hit_here;
  logic                          here;
  logic [etipf_pkg::SLOT_W-1:0]  wslot;
  etipf_pkg::token_t             tok_next;

  // compare the key with the entries held here, limited by the counts
  always_comb begin
    logic [etipf_pkg::INDEX_W-1:0] slot_index;
    slot_index     = '0;
    eth_hit_here   = 1'b0;
    proto_hit_here = 1'b0;
    for (int j = 0; j < etipf_pkg::CELL_ENTRIES; j++) begin
      slot_index = {cell_id, etipf_pkg::SLOT_W'(j)};
      if ((32'(slot_index) < 32'(cfg.ethertype_count)) &&
          (eth_entry[etipf_pkg::SLOT_W'(j)] == tok_in.outer_type)) begin
        eth_hit_here = 1'b1;
      end
      if ((32'(slot_index) < 32'(cfg.protocol_count)) &&
          (proto_entry[etipf_pkg::SLOT_W'(j)] == tok_in.proto)) begin
        proto_hit_here = 1'b1;
      end
    end
  end

  // table load addressed to this cell
  assign here  = (tok_in.index[etipf_pkg::INDEX_W-1:etipf_pkg::SLOT_W] == cell_id);
  assign wslot = tok_in.index[etipf_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (advance && tok_in.valid && here) begin
      case (tok_in.op)
        etipf_pkg::KIND_ETHERTYPE_LOAD: eth_entry[wslot] <= tok_in.value;
        etipf_pkg::KIND_PROTOCOL_LOAD:  proto_entry[wslot] <= tok_in.value[etipf_pkg::PROTO_W-1:0];
        default: ;
      endcase
    end
  end

  // fold local hits into the token
  always_comb begin
    tok_next = tok_in;
    if (tok_in.op == etipf_pkg::KIND_CLASSIFY) begin
      tok_next.eth_hit   = tok_in.eth_hit | eth_hit_here;
      tok_next.proto_hit = tok_in.proto_hit | proto_hit_here;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/ethertype_ip_protocol_filter.sv =====
// a classify request passes through the 16 cell registers in order, then the result register
// throughput: one request per cycle unless a result waits behind a full result register;
// table loads travel the same cell row
// reset: counters, search counts and actions clear to zero; table entries
// hold no defined value until loaded
module ethertype_ip_protocol_filter (
  input  logic                             clk,
  input  logic                             rst,
  etipf_pkt_if.sink                        pkt,
  etipf_res_if.source                      res,
  input  logic                             cfg_we,
  input  logic [etipf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [etipf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  etipf_pkg::cell_cfg_t cfg;
  logic                 match_action_drop;
  logic                 default_action_drop;

  etipf_pkg::token_t    cell_tok [etipf_pkg::NUM_CELLS+1];
  etipf_pkg::token_t    tail;
  logic                 advance;
  logic                 tail_result;
  logic                 tail_hit;
  logic                 tail_drop;
  logic                 out_load;
  logic                 kind_known;
  logic                 vlan_tagged;

  logic                                 res_valid;
  logic                                 verdict_pass;
  logic                                 matched;
  logic [etipf_pkg::TOTAL_W-1:0]        match_counter;
  logic [etipf_pkg::TOTAL_W-1:0]        drop_counter;
  logic [etipf_pkg::TOTAL_W-1:0]        pass_counter;
  logic [etipf_pkg::BYTE_TOTAL_W-1:0]   pass_bytes;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg                 <= '0;
      match_action_drop   <= 1'b0;
      default_action_drop <= 1'b0;
    end else if (cfg_we) begin
      case (etipf_pkg::cfg_reg_t'(cfg_index))
        etipf_pkg::CFG_ETHERTYPE_COUNT: cfg.ethertype_count <= cfg_data;
        etipf_pkg::CFG_PROTOCOL_COUNT:  cfg.protocol_count <= cfg_data;
        etipf_pkg::CFG_MATCH_ACTION:    match_action_drop <= cfg_data[0];
        etipf_pkg::CFG_DEFAULT_ACTION:  default_action_drop <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // build the entry token from the request
  always_comb begin
    case (pkt.kind)
      etipf_pkg::KIND_ETHERTYPE_LOAD,
      etipf_pkg::KIND_PROTOCOL_LOAD:
        kind_known = (32'(pkt.entry_index) < etipf_pkg::TABLE_DEPTH);
      etipf_pkg::KIND_CLASSIFY:
        kind_known = 1'b1;
      default:
        kind_known = 1'b0;
    endcase
  end

  assign vlan_tagged = (pkt.outer_type == etipf_pkg::TYPE_VLAN);

  always_comb begin
    cell_tok[0].valid      = pkt.valid & kind_known;
    cell_tok[0].op         = etipf_pkg::kind_t'(pkt.kind);
    cell_tok[0].index      = etipf_pkg::INDEX_W'(pkt.entry_index);
    cell_tok[0].value      = pkt.entry_value;
    cell_tok[0].outer_type = pkt.outer_type;
    cell_tok[0].proto      = vlan_tagged ? pkt.proto_tagged : pkt.proto_untagged;
    cell_tok[0].is_ipv4    = vlan_tagged ? (pkt.tag_inner_type == etipf_pkg::TYPE_IPV4)
                                         : (pkt.outer_type == etipf_pkg::TYPE_IPV4);
    cell_tok[0].eth_hit    = 1'b0;
    cell_tok[0].proto_hit  = 1'b0;
    cell_tok[0].length     = pkt.packet_length;
  end

  // row of table cells
  for (genvar c = 0; c < etipf_pkg::NUM_CELLS; c++) begin : g_cell
    etipf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .cell_id (etipf_pkg::CELL_ID_W'(c)),
      .cfg     (cfg),
      .tok_in  (cell_tok[c]),
      .tok_out (cell_tok[c+1])
    );
  end

  // verdict at the end of the row
  assign tail        = cell_tok[etipf_pkg::NUM_CELLS];
  assign tail_result = tail.valid && (tail.op == etipf_pkg::KIND_CLASSIFY);
  assign tail_hit    = tail.eth_hit | (tail.is_ipv4 & tail.proto_hit);
  assign tail_drop   = tail_hit ? match_action_drop : default_action_drop;

  // the row stalls only while a result waits behind a full result register
  assign advance  = !(tail_result && res_valid && !res.ready);
  assign pkt.ready = advance;
  assign out_load  = tail_result && advance;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict_pass <= ~tail_drop;
      matched      <= tail_hit;
    end
  end

  // wrapping statistics counters
  always_ff @(posedge clk) begin
    if (rst) begin
      match_counter <= '0;
      drop_counter  <= '0;
      pass_counter  <= '0;
      pass_bytes    <= '0;
    end else if (out_load) begin
      if (tail_hit) begin
        match_counter <= match_counter + 1'b1;
      end
      if (tail_drop) begin
        drop_counter <= drop_counter + 1'b1;
      end else begin
        pass_counter <= pass_counter + 1'b1;
        pass_bytes   <= pass_bytes + etipf_pkg::BYTE_TOTAL_W'(tail.length);
      end
    end
  end

  assign res.valid           = res_valid;
  assign res.verdict_pass    = verdict_pass;
  assign res.matched         = matched;
  assign res.match_total     = match_counter;
  assign res.drop_total      = drop_counter;
  assign res.pass_total      = pass_counter;
  assign res.pass_byte_total = pass_bytes;

  // a held input implies a result is waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !advance |-> (res_valid && tail_result))
    else $error("row stalled without a pending result");

  // every result loads exactly one of the drop and pass counters
  a_one_verdict_count: assert property (@(posedge clk) disable iff (rst)
    out_load |=> ((drop_counter != $past(drop_counter)) !=
                  (pass_counter != $past(pass_counter))))
    else $error("drop and pass counters out of step");

  // counters move only when a result is loaded
  a_counters_hold: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> ($stable(match_counter) && $stable(drop_counter) &&
                   $stable(pass_counter) && $stable(pass_bytes)))
    else $error("counter changed without a result");

  // match counter follows the matched flag
  a_match_count: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (res_valid &&
                  (matched == (match_counter != $past(match_counter)))))
    else $error("match counter disagrees with matched flag");

endmodule
